// ===== rtl/rsr_pkg.sv =====
package rsr_pkg;

   localparam int unsigned DistWidth = 16;
   localparam int unsigned DutyWidth = 10;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CsrIndexWidth = 1;
   localparam int unsigned CsrDataWidth = 1;
   localparam int unsigned RspDataWidth = 32;

   localparam logic [ByteWidth-1:0] CharStart = 8'h52;
   localparam logic [ByteWidth-1:0] CharCr = 8'h0D;
   localparam logic [ByteWidth-1:0] CharZero = 8'h30;
   localparam logic [ByteWidth-1:0] CharNine = 8'h39;

   localparam logic [1:0] HoldLen = 2'd2;
   localparam logic [1:0] HoldMax = 2'd3;

   localparam logic [DistWidth-1:0] DistMax = 16'hFFFF;
   localparam logic [DistWidth-1:0] LedOffset = 16'd300;
   localparam logic [DistWidth-1:0] LedTop = 16'd1300;
   localparam logic [DutyWidth-1:0] LedFull = 10'd1000;

   localparam logic [CsrIndexWidth-1:0] CsrTenHzMode = 1'b0;
   localparam logic [CsrIndexWidth-1:0] CsrSensorEnable = 1'b1;

   localparam logic ModeByte = 1'b0;
   localparam logic ModeTick = 1'b1;

   typedef struct packed {
      logic [DutyWidth-1:0] led_duty;
      logic                 enable_pin;
      logic                 distance_updated;
      logic [DistWidth-1:0] distance;
   } rsr_result_type;

   function automatic logic [DutyWidth-1:0] led_duty_of(input logic [DistWidth-1:0] d);
      logic [DistWidth-1:0] diff;
      logic [DutyWidth-1:0] duty;
      diff = LedTop - d;
      if (d <= LedOffset) begin
         duty = LedFull;
      end else if (d >= LedTop) begin
         duty = '0;
      end else begin
         duty = diff[DutyWidth-1:0];
      end
      return duty;
   endfunction

endpackage

// ===== rtl/rsr_core.sv =====
module rsr_core
   import rsr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     step,
   input  logic                     mode,
   input  logic [ByteWidth-1:0]     rx_byte,
   output rsr_result_type           result
);

   logic                 ten_hz_ff, ten_hz_in;
   logic                 sensor_en_ff, sensor_en_in;
   logic                 in_frame_ff, in_frame_in;
   logic [DistWidth-1:0] acc_ff, acc_in;
   logic [DistWidth-1:0] dist_ff, dist_in;
   logic                 hold_active_ff, hold_active_in;
   logic [1:0]           hold_ticks_ff, hold_ticks_in;
   logic                 enable_ff, enable_in;
   logic                 updated;
   logic [DistWidth+4:0] acc_sum;
   logic [1:0]           ticks_inc;
   logic [ByteWidth-1:0] digit;

   always_comb begin
      ten_hz_in = ten_hz_ff;
      sensor_en_in = sensor_en_ff;
      if (csr_wr_en) begin
         unique case (csr_index)
            CsrTenHzMode:    ten_hz_in = csr_wdata[0];
            CsrSensorEnable: sensor_en_in = csr_wdata[0];
            default: ;
         endcase
      end
   end

   assign digit = rx_byte - CharZero;
   assign acc_sum = {2'b00, acc_ff, 3'b000} + {4'b0000, acc_ff, 1'b0}
                  + {{(DistWidth+5-ByteWidth){1'b0}}, digit};
   assign ticks_inc = (hold_ticks_ff < HoldMax) ? hold_ticks_ff + 2'd1 : hold_ticks_ff;

   always_comb begin
      in_frame_in = in_frame_ff;
      acc_in = acc_ff;
      dist_in = dist_ff;
      hold_active_in = hold_active_ff;
      hold_ticks_in = hold_ticks_ff;
      enable_in = enable_ff;
      updated = 1'b0;
      if (step) begin
         if (mode == ModeByte) begin
            if (!in_frame_ff) begin
               acc_in = '0;
               if (rx_byte == CharStart) begin
                  in_frame_in = 1'b1;
                  if (ten_hz_ff) begin
                     enable_in = 1'b0;
                  end
               end
            end else if (rx_byte >= CharZero && rx_byte <= CharNine) begin
               acc_in = (acc_sum > {5'b00000, DistMax}) ? DistMax : acc_sum[DistWidth-1:0];
            end else begin
               in_frame_in = 1'b0;
               if (rx_byte == CharCr) begin
                  dist_in = acc_ff;
                  updated = 1'b1;
                  if (ten_hz_ff) begin
                     hold_active_in = 1'b1;
                     hold_ticks_in = '0;
                  end
               end
            end
         end else if (hold_active_ff) begin
            hold_ticks_in = ticks_inc;
            if (ticks_inc >= HoldLen) begin
               hold_active_in = 1'b0;
               if (sensor_en_ff) begin
                  enable_in = 1'b1;
               end
            end
         end
      end
   end

   always_comb begin
      result.distance = dist_in;
      result.distance_updated = updated;
      result.enable_pin = enable_in;
      result.led_duty = led_duty_of(dist_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ten_hz_ff <= 1'b0;
         sensor_en_ff <= 1'b1;
         in_frame_ff <= 1'b0;
         acc_ff <= '0;
         dist_ff <= '0;
         hold_active_ff <= 1'b0;
         hold_ticks_ff <= '0;
         enable_ff <= 1'b1;
      end else begin
         ten_hz_ff <= ten_hz_in;
         sensor_en_ff <= sensor_en_in;
         in_frame_ff <= in_frame_in;
         acc_ff <= acc_in;
         dist_ff <= dist_in;
         hold_active_ff <= hold_active_in;
         hold_ticks_ff <= hold_ticks_in;
         enable_ff <= enable_in;
      end
   end

endmodule

// ===== rtl/range_sensor_serial_reader.sv =====
// Parses range readings of the form 'R', decimal digits, carriage return from a stream
// of received bytes (tuser 0) and millisecond ticks (tuser 1), and gives one result beat
// per input beat: distance, update flag, enable pin level and LED duty. Each beat passes
// an input register, the parser logic and a result register, and one beat is taken every
// cycle while the result side keeps up.
module range_sensor_serial_reader
   import rsr_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_wr_en,
   input  logic [CsrIndexWidth-1:0] csr_index,
   input  logic [CsrDataWidth-1:0]  csr_wdata,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [ByteWidth-1:0]     req_tdata,   // rx_byte
   input  logic                     req_tuser,   // mode
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // distance[15:0], distance_updated[16], enable_pin[17], led_duty[27:18], zero[31:28]
   output logic [RspDataWidth-1:0]  rsp_tdata
);

   logic                 in_valid_ff, in_valid_in;
   logic                 in_mode_ff;
   logic [ByteWidth-1:0] in_byte_ff;
   logic                 out_valid_ff, out_valid_in;
   rsr_result_type       out_ff;
   rsr_result_type       result;
   logic                 advance;
   logic                 step;

   assign advance = !out_valid_ff || rsp_tready;
   assign step = in_valid_ff && advance;
   assign req_tready = !in_valid_ff || advance;
   assign in_valid_in = req_tready ? req_tvalid : in_valid_ff;
   assign out_valid_in = advance ? in_valid_ff : out_valid_ff;

   rsr_core u_core (
      .clock     (clock),
      .reset     (reset),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .step      (step),
      .mode      (in_mode_ff),
      .rx_byte   (in_byte_ff),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // hold the beat until the parser takes it
   always_ff @(posedge clock) begin
      if (req_tready) begin
         in_mode_ff <= req_tuser;
         in_byte_ff <= req_tdata;
      end
      if (step) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {{(RspDataWidth-$bits(rsr_result_type)){1'b0}}, out_ff};

endmodule
